// ===== hdl/rlet_pkg.sv =====
`default_nettype none

package rlet_pkg;

  // Register map of the configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_MARKER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_REPEATS   = 2'd1;

  localparam logic [7:0] ESCAPE_MARKER_RESET = 8'd0;
  localparam logic [7:0] MAX_REPEATS_RESET   = 8'd255;

  // Output queue: holds the two triples one byte can cause, plus slack
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] run_value;
    logic [7:0] run_length;
    logic       stream_done;
  } rlet_triple_t;

  // What one accepted byte emits: the run it closes, then the final flush
  typedef struct packed {
    logic         first_vld;
    rlet_triple_t first;
    logic         second_vld;
    rlet_triple_t second;
  } rlet_emit_t;

endpackage

`default_nettype wire

// ===== hdl/rlet_step.sv =====
`default_nettype none

module rlet_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  input  wire logic [7:0]         max_repeats,
  output rlet_pkg::rlet_emit_t    emit
);

  logic [7:0] run_byte;
  logic [7:0] repeat_count;
  logic       run_open;
  logic [7:0] run_byte_next;
  logic [7:0] repeat_count_next;
  logic       run_open_next;
  logic [7:0] new_byte;
  logic [7:0] new_count;

  always_comb begin
    emit.first_vld             = 1'b0;
    emit.first.run_value       = run_byte;
    emit.first.run_length      = repeat_count;
    emit.first.stream_done     = 1'b0;
    priority if (!run_open) begin
      new_byte  = data_byte;
      new_count = 8'd1;
    end else if (data_byte == run_byte) begin
      new_byte = run_byte;
      if (repeat_count >= max_repeats) begin
        // run full: cut it, this byte opens the next run
        emit.first_vld = 1'b1;
        new_count      = 8'd1;
      end else begin
        new_count = repeat_count + 8'd1;
      end
    end else begin
      emit.first_vld = 1'b1;
      new_byte       = data_byte;
      new_count      = 8'd1;
    end

    emit.second_vld             = last_byte;
    emit.second.run_value       = new_byte;
    emit.second.run_length      = new_count;
    emit.second.stream_done     = 1'b1;

    if (last_byte) begin
      run_open_next     = 1'b0;
      run_byte_next     = 8'd0;
      repeat_count_next = 8'd0;
    end else begin
      run_open_next     = 1'b1;
      run_byte_next     = new_byte;
      repeat_count_next = new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open     <= 1'b0;
      run_byte     <= 8'd0;
      repeat_count <= 8'd0;
    end else if (advance) begin
      run_open     <= run_open_next;
      run_byte     <= run_byte_next;
      repeat_count <= repeat_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rlet_queue.sv =====
`default_nettype none

module rlet_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire rlet_pkg::rlet_emit_t  emit,
  input  wire logic                  pop,
  output rlet_pkg::rlet_triple_t     head,
  output logic                       not_empty,
  output logic                       room_for_two
);

  rlet_pkg::rlet_triple_t mem [rlet_pkg::QUEUE_DEPTH];

  logic [rlet_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [rlet_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [rlet_pkg::QUEUE_CNT_W-1:0] count;
  logic [rlet_pkg::QUEUE_CNT_W-1:0] count_next;
  logic [rlet_pkg::QUEUE_CNT_W-1:0] n_push;
  logic [rlet_pkg::QUEUE_CNT_W-1:0] n_pop;
  rlet_pkg::rlet_triple_t           entry0;

  // pack the emitted triples to the front
  assign entry0 = emit.first_vld ? emit.first : emit.second;

  always_comb begin
    n_push = '0;
    if (push) begin
      n_push = rlet_pkg::QUEUE_CNT_W'(emit.first_vld)
             + rlet_pkg::QUEUE_CNT_W'(emit.second_vld);
    end
    n_pop      = rlet_pkg::QUEUE_CNT_W'(pop);
    count_next = count + n_push - n_pop;
  end

  assign head         = mem[rd_ptr];
  assign not_empty    = (count != '0);
  assign room_for_two = (count <= rlet_pkg::QUEUE_CNT_W'(rlet_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (n_push != '0) begin
      mem[wr_ptr] <= entry0;
    end
    if (n_push == rlet_pkg::QUEUE_CNT_W'(2)) begin
      mem[wr_ptr + rlet_pkg::QUEUE_PTR_W'(1)] <= emit.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[rlet_pkg::QUEUE_PTR_W-1:0];
      rd_ptr <= rd_ptr + rlet_pkg::QUEUE_PTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rle_triple_encoder.sv =====
// Run-length encoder, every run coded as a triple (marker, value, length).
// Byte channel: data_byte/last_byte with data_valid, data_stall. A word is
//   taken at a clock edge with data_valid high and data_stall low.
// Triple channel: marker_byte/run_value/run_length/stream_done with
//   triple_valid, triple_stall; same rule, receiver drives triple_stall.
// Config: cfg_valid/cfg_ready, cfg_index 0 = escape marker, 1 = max
//   repeats; other indexes are dropped. cfg_ready is always high. Write
//   only while no triples are pending.
// Throughput: one byte per cycle unless stalled. A byte may close a
//   run and, with last_byte, flush the final run, so it can cause two
//   triples. They go into a 4-entry output queue; data_stall rises when
//   fewer than two slots are free, so two-triple bytes drain at the
//   output rate. A triple is queued at the edge that takes its byte.
// Reset (rst, synchronous): queue empty, no open run, registers to
//   marker 0 and max repeats 255. A stalled triple holds until taken.
`default_nettype none

module rle_triple_encoder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // byte input
  input  wire logic                             data_valid,
  output logic                                  data_stall,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             last_byte,
  // triple output
  output logic                                  triple_valid,
  input  wire logic                             triple_stall,
  output logic [7:0]                            marker_byte,
  output logic [7:0]                            run_value,
  output logic [7:0]                            run_length,
  output logic                                  stream_done,
  // configuration
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rlet_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data
);

  logic [7:0]             escape_marker;
  logic [7:0]             max_repeats;
  logic                   data_take;
  logic                   triple_take;
  logic                   room_for_two;
  rlet_pkg::rlet_emit_t   emit;
  rlet_pkg::rlet_triple_t head;

  // config registers; writes never wait
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_marker <= rlet_pkg::ESCAPE_MARKER_RESET;
      max_repeats   <= rlet_pkg::MAX_REPEATS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rlet_pkg::REG_ESCAPE_MARKER: escape_marker <= cfg_data;
        rlet_pkg::REG_MAX_REPEATS:   max_repeats   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall depends on queue fill only, so the byte side never waits on valid
  assign data_stall  = !room_for_two;
  assign data_take   = data_valid && !data_stall;
  assign triple_take = triple_valid && !triple_stall;

  // run tracking: compare, count, decide what to emit
  rlet_step u_step (
    .clk         (clk),
    .rst         (rst),
    .advance     (data_take),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .max_repeats (max_repeats),
    .emit        (emit)
  );

  // result queue decouples the two sides
  rlet_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (data_take),
    .emit         (emit),
    .pop          (triple_take),
    .head         (head),
    .not_empty    (triple_valid),
    .room_for_two (room_for_two)
  );

  // user keeps marker stable while triples are pending; no check here
  assign marker_byte = escape_marker;
  assign run_value   = head.run_value;
  assign run_length  = head.run_length;
  assign stream_done = head.stream_done;

endmodule

`default_nettype wire

// ===== hdl/rlet_checker.sv =====
`default_nettype none

module rlet_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       data_valid,
  input wire logic       data_stall,
  input wire logic       last_byte,
  input wire logic       triple_valid,
  input wire logic       triple_stall,
  input wire logic [7:0] marker_byte,
  input wire logic [7:0] run_value,
  input wire logic [7:0] run_length,
  input wire logic       stream_done
);

  // reset empties the queue and opens the byte side
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !triple_valid && !data_stall)
    else $error("outputs not cleared after reset");

  // a stalled triple holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    triple_valid && triple_stall |=>
      triple_valid && $stable(run_value) && $stable(run_length)
      && $stable(stream_done) && $stable(marker_byte))
    else $error("stalled triple changed");

  // every emitted run holds at least one byte
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    triple_valid |-> run_length != 8'd0)
    else $error("zero length run");

  // a last byte always produces the final flush
  a_last_flushes: assert property (@(posedge clk) disable iff (rst)
    data_valid && !data_stall && last_byte |=> triple_valid)
    else $error("last byte gave no triple");

endmodule

bind rle_triple_encoder rlet_checker u_rlet_checker (
  .clk          (clk),
  .rst          (rst),
  .data_valid   (data_valid),
  .data_stall   (data_stall),
  .last_byte    (last_byte),
  .triple_valid (triple_valid),
  .triple_stall (triple_stall),
  .marker_byte  (marker_byte),
  .run_value    (run_value),
  .run_length   (run_length),
  .stream_done  (stream_done)
);

`default_nettype wire

// ===== tb/rlet_triple_checker.sv =====
`default_nettype none

module rlet_triple_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             data_valid,
  input  wire logic                             data_stall,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             last_byte,
  input  wire logic                             triple_valid,
  input  wire logic                             triple_stall,
  input  wire logic [7:0]                       marker_byte,
  input  wire logic [7:0]                       run_value,
  input  wire logic [7:0]                       run_length,
  input  wire logic                             stream_done,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [rlet_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data,
  output int                                    errors,
  output int                                    pending,
  output int                                    bytes_seen,
  output int                                    triples_seen,
  output int                                    writes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]             marker;
    rlet_pkg::rlet_triple_t body;
  } coded_run_t;

  coded_run_t run_fifo[$];
  coded_run_t oldest;

  // shadow registers and run tracker
  logic [7:0] marker_reg;
  logic [7:0] max_rep_reg;
  logic [7:0] cur_val;
  logic [7:0] cur_cnt;
  logic       cur_open;

  function automatic void emit_run(input logic [7:0] v, input logic [7:0] n,
                                   input logic fin);
    coded_run_t w;
    w.marker = marker_reg;
    w.body.run_value = v;
    w.body.run_length = n;
    w.body.stream_done = fin;
    run_fifo.push_back(w);
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    if (!cur_open) begin
      cur_val = b;
      cur_cnt = 8'd1;
      cur_open = 1'b1;
    end else if (b == cur_val) begin
      if (cur_cnt >= max_rep_reg) begin
        emit_run(cur_val, cur_cnt, 1'b0);
        cur_cnt = 8'd1;
      end else begin
        cur_cnt = cur_cnt + 8'd1;
      end
    end else begin
      emit_run(cur_val, cur_cnt, 1'b0);
      cur_val = b;
      cur_cnt = 8'd1;
    end
    if (fin) begin
      emit_run(cur_val, cur_cnt, 1'b1);
      cur_open = 1'b0;
      cur_val = 8'd0;
      cur_cnt = 8'd0;
    end
  endfunction

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      marker_reg = rlet_pkg::ESCAPE_MARKER_RESET;
      max_rep_reg = rlet_pkg::MAX_REPEATS_RESET;
      cur_val = 8'd0;
      cur_cnt = 8'd0;
      cur_open = 1'b0;
      run_fifo.delete();
    end else begin
      if (triple_valid && !triple_stall) begin
        triples_seen++;
        if (run_fifo.size() == 0) begin
          errors++;
          $display("%0t: triple with none expected, expected nothing, actual %h %h %0d %b",
                   $time, marker_byte, run_value, run_length, stream_done);
        end else begin
          oldest = run_fifo.pop_front();
          check_field("marker_byte", oldest.marker, marker_byte);
          check_field("run_value", oldest.body.run_value, run_value);
          check_field("run_length", oldest.body.run_length, run_length);
          check_field("stream_done", {7'd0, oldest.body.stream_done}, {7'd0, stream_done});
        end
      end
      if (data_valid && !data_stall) begin
        bytes_seen++;
        encode_byte(data_byte, last_byte);
      end
      // register writes apply from the next word on
      if (cfg_valid && cfg_ready) begin
        writes_seen++;
        case (cfg_index)
          rlet_pkg::REG_ESCAPE_MARKER: marker_reg = cfg_data;
          rlet_pkg::REG_MAX_REPEATS:   max_rep_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending = run_fifo.size();
  end

endmodule

`default_nettype wire

// ===== tb/rle_triple_encoder_tb.sv =====
`default_nettype none

module rle_triple_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // indexes outside the register map, must be dropped by the block
  localparam logic [rlet_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [rlet_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int BYTE_TARGET = 1320;  // stop making random streams here
  localparam int QUIET_FROM  = 1150;  // no idling on either side after this

  logic                             clk;
  logic                             rst;
  logic                             data_valid;
  logic                             data_stall;
  logic [7:0]                       data_byte;
  logic                             last_byte;
  logic                             triple_valid;
  logic                             triple_stall;
  logic [7:0]                       marker_byte;
  logic [7:0]                       run_value;
  logic [7:0]                       run_length;
  logic                             stream_done;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [rlet_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]                       cfg_data;

  int errors;
  int pending;
  int bytes_seen;
  int triples_seen;
  int writes_seen;

  // stimulus bookkeeping
  int   bytes_sent;
  bit   idle_on;
  int   max_written;  // last max_repeats value, steers run lengths
  logic byte_taken;
  logic cfg_taken;

  rle_triple_encoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .triple_valid (triple_valid),
    .triple_stall (triple_stall),
    .marker_byte  (marker_byte),
    .run_value    (run_value),
    .run_length   (run_length),
    .stream_done  (stream_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rlet_triple_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .triple_valid (triple_valid),
    .triple_stall (triple_stall),
    .marker_byte  (marker_byte),
    .run_value    (run_value),
    .run_length   (run_length),
    .stream_done  (stream_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .bytes_seen   (bytes_seen),
    .triples_seen (triples_seen),
    .writes_seen  (writes_seen)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // handshake flags, captured at the edge and looked at on the falling edge
  always @(posedge clk) begin
    byte_taken <= data_valid && !data_stall;
    cfg_taken  <= cfg_valid && cfg_ready;
  end

  // output side back-pressure: random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    triple_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        stall_left = 0;
        triple_stall = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        triple_stall = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        triple_stall = 1'b1;
      end else begin
        triple_stall = 1'b0;
      end
    end
  end

  // Present one word and hold it until taken. Called and returns on a
  // falling edge, so valid is written at most once per step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      data_valid = 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    data_valid = 1'b1;
    data_byte = b;
    last_byte = fin;
    do @(negedge clk); while (!byte_taken);
    bytes_sent++;
  endtask

  // Registers change only with nothing in flight; the few extra cycles
  // cover a word that closed no run but is still being absorbed.
  task automatic write_reg(input logic [rlet_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] val);
    data_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
    if (idx == rlet_pkg::REG_MAX_REPEATS) max_written = int'(val);
  endtask

  task automatic send_run(input logic [7:0] v, input int n, input logic fin);
    for (int k = 0; k < n; k++) send_byte(v, fin && (k == n - 1));
  endtask

  task automatic random_write();
    logic [rlet_pkg::CFG_INDEX_W-1:0] idx;
    logic [7:0]                       val;
    idx = rlet_pkg::CFG_INDEX_W'($urandom_range(0, 3));
    val = 8'($urandom);
    if (idx == rlet_pkg::REG_MAX_REPEATS) begin
      case ($urandom_range(0, 5))
        0: val = 8'd1;
        1: val = 8'd255;
        2: val = 8'($urandom_range(2, 8));
        3: val = 8'd0;
        default: ;
      endcase
    end
    write_reg(idx, val);
  endtask

  // Mostly well-formed streams of runs closed by the last flag; the rest
  // is raw noise whose flag may or may not come, leaving runs open.
  task automatic random_stream();
    int         nruns;
    int         len;
    int         cap;
    logic [7:0] v;
    if ($urandom_range(0, 9) < 8) begin
      nruns = $urandom_range(1, 8);
      for (int r = 0; r < nruns; r++) begin
        v = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        cap = (max_written == 0) ? 3 : max_written + 2;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cap) : $urandom_range(1, 6);
        send_run(v, len, r == nruns - 1);
      end
    end else begin
      len = $urandom_range(1, 20);
      for (int k = 0; k < len; k++) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    data_valid = 1'b0;
    data_byte = 8'd0;
    last_byte = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = rlet_pkg::REG_ESCAPE_MARKER;
    cfg_data = 8'd0;
    idle_on = 1'b1;
    bytes_sent = 0;
    max_written = int'(rlet_pkg::MAX_REPEATS_RESET);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part, reset register values first ---
    // single word that both opens and flushes a stream
    send_byte(8'h00, 1'b1);
    // run of two, a value change, then a word that closes one run and
    // flushes another: two triples from one word
    send_run(8'hFF, 2, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);

    // max repeats 1: every equal word cuts the run
    write_reg(rlet_pkg::REG_ESCAPE_MARKER, 8'hFF);
    write_reg(rlet_pkg::REG_MAX_REPEATS, 8'd1);
    send_run(8'h55, 4, 1'b1);

    // max repeats 0 behaves like 1
    write_reg(rlet_pkg::REG_MAX_REPEATS, 8'd0);
    write_reg(rlet_pkg::REG_ESCAPE_MARKER, 8'h80);
    send_run(8'h7E, 3, 1'b1);

    // lower the cut point under an open run of four
    write_reg(rlet_pkg::REG_MAX_REPEATS, 8'd5);
    write_reg(rlet_pkg::REG_ESCAPE_MARKER, 8'h01);
    send_run(8'h33, 4, 1'b0);
    write_reg(rlet_pkg::REG_MAX_REPEATS, 8'd2);
    send_run(8'h33, 2, 1'b1);

    // writes to unmapped indexes leave both registers alone
    write_reg(REG_SPARE_A, 8'h00);
    write_reg(REG_SPARE_B, 8'hFF);
    send_byte(8'hC3, 1'b1);

    // --- long runs at the widest cut point: full 255 lengths ---
    write_reg(rlet_pkg::REG_MAX_REPEATS, 8'd255);
    for (int k = 0; k < 2; k++) begin
      write_reg(rlet_pkg::REG_ESCAPE_MARKER, 8'($urandom));
      send_run(8'($urandom), $urandom_range(255, 560), 1'b1);
    end

    // --- random part ---
    while (bytes_sent < BYTE_TARGET) begin
      idle_on = (bytes_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) random_write();
      random_stream();
    end
    idle_on = 1'b0;
    send_byte(8'($urandom), 1'b1);  // close whatever run is still open
    data_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Run covered %0d bytes and %0d triples, %0d register writes.",
             bytes_seen, triples_seen, writes_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #10_000_000;
    $display("Timed out with %0d triples outstanding", pending);
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== rle_triple_encoder.f =====
hdl/rlet_pkg.sv
hdl/rlet_step.sv
hdl/rlet_queue.sv
hdl/rle_triple_encoder.sv
hdl/rlet_checker.sv
tb/rlet_triple_checker.sv
tb/rle_triple_encoder_tb.sv
